// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define WTS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("world_to_screen assertion failed");

// Checked on every clock edge, reset included.
`define WTS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("world_to_screen assertion failed");

`endif

// File: hw/rtl/wts_pkg.sv
`default_nettype none
package wts_pkg;

    localparam int DEF_FRAC_BITS = 16;
    // Quotient bits worked out by the divider; results are capped at 2^(QUOT_BITS-1).
    localparam int QUOT_BITS     = 41;
    localparam int IDX_W         = 4;
    localparam int SIZE_W        = 14;

    localparam logic [IDX_W-1:0] REG_M0_01  = 4'd0;
    localparam logic [IDX_W-1:0] REG_M0_23  = 4'd1;
    localparam logic [IDX_W-1:0] REG_M1_01  = 4'd2;
    localparam logic [IDX_W-1:0] REG_M1_23  = 4'd3;
    localparam logic [IDX_W-1:0] REG_M3_01  = 4'd4;
    localparam logic [IDX_W-1:0] REG_M3_23  = 4'd5;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 4'd6;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 4'd7;

    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 14'd1920;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 14'd1080;

    // Per-item flags that ride alongside the divider data.
    typedef struct packed {
        logic visible;
        logic sign_x;
        logic sign_y;
    } wts_side_t;

endpackage
`default_nettype wire

// File: hw/rtl/world_to_screen_projection_unit.sv
// World-to-screen projection: one Q FRAC_BITS world point in, one pixel position out.
// Input stream s_*: s_tdata carries world_x, world_y, world_z (32 bits each).
// Output stream m_*: m_tdata carries pixel_x, pixel_y; m_tuser carries visible.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Indices 0 to 5 hold the matrix rows, 6 the width, 7 the height;
// other indices are ignored. Write configuration only while the pipeline is empty.
// Throughput: one point per cycle while the output is not stalled. The divider is
// a restoring divider, which retires one quotient bit per stage for x and y.
// Stages: multiply, row sums, numerator multiply, overflow test, divider steps,
// screen mapping with saturation into the output register.
// Points with w below 0.001 come out with visible low and zero coordinates.
// Reset clears every valid bit, the matrix to zero and the viewport to 1920x1080.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated, and bubbles still fill while
// the output register is empty.
`default_nettype none
module world_to_screen_projection_unit import wts_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [95:0]       s_tdata,   // world_x, world_y, world_z
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [63:0]            m_tdata,   // pixel_x, pixel_y
    output logic [0:0]             m_tuser,   // visible
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]       cfg_data
);

    localparam int CW = 66 - FRAC_BITS;          // clip value, signed
    localparam int MW = CW - 1;                  // clip magnitude
    localparam int NW = MW + SIZE_W + FRAC_BITS - 1;
    localparam int QB = QUOT_BITS;
    localparam int PW = QB + 3;
    localparam logic [CW-1:0] THRESH = CW'(((64'd1 << FRAC_BITS) + 64'd999) / 64'd1000);
    localparam logic signed [PW-1:0] SAT_MAX = PW'(32'h7fff_ffff);
    localparam logic signed [PW-1:0] SAT_MIN = -SAT_MAX - PW'(1);
    localparam logic signed [PW-1:0] HALF    = PW'(1) << (FRAC_BITS - 1);

    logic [63:0]       mat_reg [0:5];
    logic [SIZE_W-1:0] scr_w_reg, scr_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) mat_reg[i] <= '0;
            scr_w_reg <= RESET_WIDTH;
            scr_h_reg <= RESET_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index) inside
                REG_M0_01, REG_M0_23, REG_M1_01, REG_M1_23, REG_M3_01, REG_M3_23:
                    mat_reg[cfg_index[2:0]] <= cfg_data;
                REG_WIDTH:  scr_w_reg <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT: scr_h_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Matrix entries, rows in order 0, 1, 3.
    logic signed [31:0] ent [0:2][0:3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            ent[r][0] = mat_reg[2*r][31:0];
            ent[r][1] = mat_reg[2*r][63:32];
            ent[r][2] = mat_reg[2*r+1][31:0];
            ent[r][3] = mat_reg[2*r+1][63:32];
        end
    end

    logic signed [31:0] pt [0:2];
    assign pt[0] = s_tdata[31:0];
    assign pt[1] = s_tdata[63:32];
    assign pt[2] = s_tdata[95:64];

    // Stage 1: the nine products.
    logic               v1_reg;
    logic signed [63:0] prod_reg [0:2][0:2];
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= s_tvalid;
        if (en) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= ent[r][c] * pt[c];
        end
    end

    // Stage 2: floor each product and add the translation column.
    logic               v2_reg;
    logic signed [CW-1:0] clip_reg [0:2];
    logic signed [CW-1:0] clip_next [0:2];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            clip_next[r] = CW'(ent[r][3]);
            for (int c = 0; c < 3; c++)
                clip_next[r] = clip_next[r] + CW'(prod_reg[r][c] >>> FRAC_BITS);
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
        if (en) begin
            for (int r = 0; r < 3; r++) clip_reg[r] <= clip_next[r];
        end
    end

    // Stage 3: visibility, magnitudes and scaled numerators.
    logic [CW-1:0] neg_x, neg_y;
    logic [MW-1:0] mag_x, mag_y;
    assign neg_x = -clip_reg[0];
    assign neg_y = -clip_reg[1];
    assign mag_x = clip_reg[0][CW-1] ? neg_x[MW-1:0] : clip_reg[0][MW-1:0];
    assign mag_y = clip_reg[1][CW-1] ? neg_y[MW-1:0] : clip_reg[1][MW-1:0];

    logic          v3_reg;
    wts_side_t     side3_reg;
    logic [NW-1:0] num_x_reg, num_y_reg;
    logic [MW-1:0] den_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= v2_reg;
        if (en) begin
            side3_reg.visible <= clip_reg[2] >= $signed(THRESH);
            side3_reg.sign_x  <= clip_reg[0][CW-1];
            side3_reg.sign_y  <= clip_reg[1][CW-1];
            num_x_reg <= (NW'(mag_x) * NW'(scr_w_reg)) << (FRAC_BITS - 1);
            num_y_reg <= (NW'(mag_y) * NW'(scr_h_reg)) << (FRAC_BITS - 1);
            den_reg   <= clip_reg[2][MW-1:0];
        end
    end

    logic          dv;
    wts_side_t     dside;
    logic [QB-1:0] qx, qy;

    wts_div_pipe #(.MW(MW), .NW(NW), .QB(QB)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_side   (side3_reg),
        .in_num_x  (num_x_reg),
        .in_num_y  (num_y_reg),
        .in_den    (den_reg),
        .out_valid (dv),
        .out_side  (dside),
        .out_q_x   (qx),
        .out_q_y   (qy)
    );

    // Final stage: centre offset, rounding half and saturation.
    logic signed [PW-1:0] sq_x, sq_y, off_w, off_h, px, py;
    logic [31:0] px_sat, py_sat;
    assign sq_x  = dside.sign_x ? -$signed(PW'(qx)) : $signed(PW'(qx));
    assign sq_y  = dside.sign_y ? -$signed(PW'(qy)) : $signed(PW'(qy));
    assign off_w = $signed(PW'(scr_w_reg >> 1)) <<< FRAC_BITS;
    assign off_h = $signed(PW'(scr_h_reg >> 1)) <<< FRAC_BITS;
    assign px    = off_w + sq_x + HALF;
    assign py    = off_h - (sq_y + HALF);
    assign px_sat = (px > SAT_MAX) ? SAT_MAX[31:0] : (px < SAT_MIN) ? SAT_MIN[31:0] : px[31:0];
    assign py_sat = (py > SAT_MAX) ? SAT_MAX[31:0] : (py < SAT_MIN) ? SAT_MIN[31:0] : py[31:0];

    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic        m_vis_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en)  m_valid_reg <= dv;
        if (en) begin
            m_vis_reg  <= dside.visible;
            m_data_reg <= dside.visible ? {py_sat, px_sat} : 64'd0;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_vis_reg;

endmodule
`default_nettype wire

// File: hw/rtl/wts_div_pipe.sv
`default_nettype none
module wts_div_pipe import wts_pkg::*; #(
    parameter int MW = 49,
    parameter int NW = 78,
    parameter int QB = QUOT_BITS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire wts_side_t     in_side,
    input  wire logic [NW-1:0] in_num_x,
    input  wire logic [NW-1:0] in_num_y,
    input  wire logic [MW-1:0] in_den,
    output logic               out_valid,
    output wts_side_t          out_side,
    output logic [QB-1:0]      out_q_x,
    output logic [QB-1:0]      out_q_y
);

    localparam int HW = NW - QB;
    localparam int XW = (HW > MW) ? HW : MW;
    localparam logic [QB-1:0] CAP = QB'(1) << (QB - 1);

    logic            valid_reg [0:QB];
    wts_side_t       side_reg  [0:QB];
    logic [MW-1:0]   den_reg   [0:QB];
    logic            ovx_reg   [0:QB];
    logic            ovy_reg   [0:QB];
    logic [MW-1:0]   rx_reg    [0:QB];
    logic [MW-1:0]   ry_reg    [0:QB];
    logic [QB-1:0]   lox_reg   [0:QB];
    logic [QB-1:0]   loy_reg   [0:QB];
    logic [QB-1:0]   qx_reg    [0:QB];
    logic [QB-1:0]   qy_reg    [0:QB];

    logic [XW-1:0] hix, hiy, denx;
    assign hix  = XW'(in_num_x[NW-1:QB]);
    assign hiy  = XW'(in_num_y[NW-1:QB]);
    assign denx = XW'(in_den);

    // Entry stage: a high part at or above the divisor means the quotient overflows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
        if (en) begin
            side_reg[0] <= in_side;
            den_reg[0]  <= in_den;
            ovx_reg[0]  <= hix >= denx;
            ovy_reg[0]  <= hiy >= denx;
            rx_reg[0]   <= hix[MW-1:0];
            ry_reg[0]   <= hiy[MW-1:0];
            lox_reg[0]  <= in_num_x[QB-1:0];
            loy_reg[0]  <= in_num_y[QB-1:0];
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [MW:0] trial_x, trial_y;
        logic        take_x, take_y;
        assign trial_x = {rx_reg[k-1], lox_reg[k-1][QB-k]};
        assign trial_y = {ry_reg[k-1], loy_reg[k-1][QB-k]};
        assign take_x  = trial_x >= {1'b0, den_reg[k-1]};
        assign take_y  = trial_y >= {1'b0, den_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
            if (en) begin
                side_reg[k] <= side_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                ovx_reg[k]  <= ovx_reg[k-1];
                ovy_reg[k]  <= ovy_reg[k-1];
                lox_reg[k]  <= lox_reg[k-1];
                loy_reg[k]  <= loy_reg[k-1];
                rx_reg[k]   <= take_x ? MW'(trial_x - {1'b0, den_reg[k-1]})
                                      : trial_x[MW-1:0];
                ry_reg[k]   <= take_y ? MW'(trial_y - {1'b0, den_reg[k-1]})
                                      : trial_y[MW-1:0];
                qx_reg[k]   <= {qx_reg[k-1][QB-2:0], take_x};
                qy_reg[k]   <= {qy_reg[k-1][QB-2:0], take_y};
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign out_side  = side_reg[QB];
    assign out_q_x   = (ovx_reg[QB] || qx_reg[QB] > CAP) ? CAP : qx_reg[QB];
    assign out_q_y   = (ovy_reg[QB] || qy_reg[QB] > CAP) ? CAP : qy_reg[QB];

endmodule
`default_nettype wire

// File: hw/rtl/wts_checker.sv
`default_nettype none
`include "assert_macros.svh"
module wts_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // Reset empties the output register.
    `WTS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    // A waiting result holds until it is taken.
    `WTS_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // A blocked output freezes the pipeline, so no new request is taken.
    `WTS_ASSERT(a_stall_in, aclk, aresetn, m_tvalid && !m_tready |-> !s_tready)
    // Points behind the viewer carry zero coordinates.
    `WTS_ASSERT(a_hidden_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)

endmodule

bind world_to_screen_projection_unit wts_checker u_wts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// File: test/world_to_screen_projection_unit_test.sv
`default_nettype none
module world_to_screen_projection_unit_test import wts_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = DEF_FRAC_BITS;
    localparam longint ONE = longint'(1) << FB;
    localparam longint W_MIN = (ONE + 999) / 1000;
    localparam int LATENCY = QUOT_BITS + 5;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_POINTS = 500;
    localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    typedef struct packed {
        logic        visible;
        logic [31:0] pixel_x;
        logic [31:0] pixel_y;
    } pixel_t;

    typedef struct {
        logic [63:0]       mat [6];
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } view_t;

    typedef struct {
        int          view;
        logic [31:0] x, y, z;
        bit          known;
        pixel_t      want;
    } point_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [95:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [63:0]          cfg_data = '0;

    // Shadow copy of the configuration, updated as each write request is taken.
    logic [63:0]          mat_q [6];
    logic [SIZE_W-1:0]    width_q = RESET_WIDTH;
    logic [SIZE_W-1:0]    height_q = RESET_HEIGHT;

    pixel_t pending_pixels [$];
    int     errors = 0;
    int     quiet_cycles = 0;
    bit     no_idle = 1'b0;
    bit     hold_output = 1'b0;

    world_to_screen_projection_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clip_row(logic [63:0] lo, logic [63:0] hi,
                                        logic [31:0] x, logic [31:0] y, logic [31:0] z);
        longint sum;
        sum = longint'($signed(hi[63:32]));
        sum += (longint'($signed(lo[31:0])) * longint'($signed(x))) >>> FB;
        sum += (longint'($signed(lo[63:32])) * longint'($signed(y))) >>> FB;
        sum += (longint'($signed(hi[31:0])) * longint'($signed(z))) >>> FB;
        return sum;
    endfunction

    // c * size * 2^(FB-1) / w, truncated toward zero, magnitude capped.
    function automatic longint perspective_offset(longint c, logic [SIZE_W-1:0] size,
                                                  longint w);
        logic [127:0] num, q, cap;
        logic [63:0]  mag;
        mag = (c < 0) ? 64'(-c) : 64'(c);
        cap = 128'(1) << (QUOT_BITS - 1);
        num = 128'(mag) * (128'(size) << (FB - 1));
        q = num / 128'(w);
        if (q > cap)
            q = cap;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > longint'($signed(S32_MAX)))
            return S32_MAX;
        if (v < longint'($signed(S32_MIN)))
            return S32_MIN;
        return v[31:0];
    endfunction

    function automatic pixel_t project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        pixel_t p;
        longint cx, cy, cw, half;
        cx = clip_row(mat_q[0], mat_q[1], x, y, z);
        cy = clip_row(mat_q[2], mat_q[3], x, y, z);
        cw = clip_row(mat_q[4], mat_q[5], x, y, z);
        half = longint'(1) << (FB - 1);
        p = '{1'b0, 32'd0, 32'd0};
        if (cw >= W_MIN) begin
            p.visible = 1'b1;
            p.pixel_x = clamp32((longint'(width_q >> 1) << FB)
                                + perspective_offset(cx, width_q, cw) + half);
            p.pixel_y = clamp32((longint'(height_q >> 1) << FB)
                                - (perspective_offset(cy, height_q, cw) + half));
        end
        return p;
    endfunction

    // Monitor: predicts on each accepted point, checks each accepted pixel.
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index) inside
                    REG_M0_01, REG_M0_23, REG_M1_01, REG_M1_23, REG_M3_01, REG_M3_23:
                        mat_q[cfg_index[2:0]] = cfg_data;
                    REG_WIDTH:  width_q = cfg_data[SIZE_W-1:0];
                    REG_HEIGHT: height_q = cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_pixels.insert(pending_pixels.size(),
                                      project_point(s_tdata[31:0], s_tdata[63:32],
                                                    s_tdata[95:64]));
            if (m_tvalid && m_tready) begin
                if (pending_pixels.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected pixel %h visible %b", m_tdata, m_tuser[0]);
                end else begin
                    want = pending_pixels.pop_front();
                    if (want.visible !== m_tuser[0] || want.pixel_x !== m_tdata[31:0]
                            || want.pixel_y !== m_tdata[63:32]) begin
                        errors++;
                        if (errors <= 10)
                            $display("pixel mismatch: expected vis %b x %h y %h, got vis %b x %h y %h",
                                     want.visible, want.pixel_x, want.pixel_y,
                                     m_tuser[0], m_tdata[31:0], m_tdata[63:32]);
                    end
                end
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold while points keep coming.
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_output = 1'b0;
            end
            m_tready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    initial begin
        @(posedge aclk);
        wait (quiet_cycles >= STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_view(view_t v);
        wait (pending_pixels.size() == 0);
        repeat (LATENCY + 4) @(posedge aclk);
        for (int r = 0; r < 6; r++)
            write_reg(IDX_W'(r), v.mat[r]);
        // Upper bits of the size words are random; only the low bits count.
        write_reg(REG_WIDTH, {$urandom, 18'($urandom), v.width});
        write_reg(REG_HEIGHT, {$urandom, 18'($urandom), v.height});
        write_reg(IDX_W'($urandom_range(15, 8)), {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while (!no_idle && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(9))
            0: return $urandom;
            1: case ($urandom_range(3))
                   0: return S32_MAX;
                   1: return S32_MIN;
                   2: return 32'd0;
                   default: return 32'hffff_ffff;
               endcase
            default: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
        endcase
    endfunction

    function automatic logic [31:0] random_entry();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'd0;
            default: return 32'($signed($urandom_range(1 << 18)) - (1 << 17));
        endcase
    endfunction

    function automatic view_t random_view();
        view_t v;
        for (int r = 0; r < 6; r++)
            v.mat[r] = {random_entry(), random_entry()};
        // Keep the w row mostly in front of the viewer so that division is exercised.
        if ($urandom_range(3) != 0)
            v.mat[5][63:32] = 32'($urandom_range(32'h0040_0000, 32'h0000_0040));
        case ($urandom_range(3))
            0: v.width = SIZE_W'($urandom_range(8192, 1));
            1: v.width = SIZE_W'($urandom);
            default: v.width = SIZE_W'($urandom_range(2048, 1));
        endcase
        v.height = ($urandom_range(3) == 0) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(8192, 1));
        return v;
    endfunction

    view_t      views [5];
    point_row_t directed [$];

    initial begin
        int     current;
        pixel_t blank;
        for (int r = 0; r < 6; r++)
            mat_q[r] = '0;
        blank = '{1'b0, 32'd0, 32'd0};
        // View 0 is the reset state: a zero matrix puts every point behind the viewer.
        views[0] = '{'{default: 64'd0}, RESET_WIDTH, RESET_HEIGHT};
        views[1] = '{'{64'(ONE), 64'd0, 64'(ONE) << 32, 64'd0, 64'd0, 64'(ONE) << 32},
                     RESET_WIDTH, RESET_HEIGHT};
        // w exactly on the behind threshold, and one below it via the z column.
        views[2] = '{'{64'(ONE), 64'd0, 64'(ONE) << 32, 64'd0,
                       64'd0, {32'(W_MIN), 32'hffff_ffff}}, 14'd8192, 14'd8192};
        views[3] = '{'{64'(ONE), 64'd0, 64'(ONE) << 32, 64'd0, 64'd0, 64'(ONE) << 32},
                     14'd0, 14'd0};
        views[4] = '{'{64'(ONE), 64'd0, 64'(ONE) << 32, 64'd0, 64'd0, 64'(ONE) << 32},
                     14'd1, 14'd16383};

        directed.insert(directed.size(), '{0, 32'd0, 32'd0, 32'd0, 1'b1, blank});
        directed.insert(directed.size(), '{0, S32_MAX, S32_MAX, S32_MAX, 1'b1, blank});
        directed.insert(directed.size(), '{0, S32_MIN, S32_MIN, S32_MIN, 1'b1, blank});
        directed.insert(directed.size(), '{1, 32'd0, 32'd0, 32'd0, 1'b1,
                             '{1'b1, 32'((960 << FB) + (1 << (FB - 1))),
                               32'((540 << FB) - (1 << (FB - 1)))}});
        directed.insert(directed.size(), '{1, 32'(ONE), 32'(ONE), 32'd0, 1'b0, blank});
        directed.insert(directed.size(), '{1, S32_MAX, S32_MIN, S32_MAX, 1'b0, blank});
        directed.insert(directed.size(), '{1, S32_MIN, S32_MAX, S32_MIN, 1'b0, blank});
        directed.insert(directed.size(), '{2, 32'd0, 32'd0, 32'd0, 1'b0, blank});
        directed.insert(directed.size(), '{2, 32'd1, 32'hffff_ffff, 32'd0, 1'b0, blank});
        directed.insert(directed.size(), '{2, S32_MAX, S32_MIN, 32'd0, 1'b0, blank});
        directed.insert(directed.size(), '{2, S32_MIN, S32_MAX, 32'd0, 1'b0, blank});
        directed.insert(directed.size(), '{2, 32'd0, 32'd0, 32'(ONE), 1'b1, blank});
        directed.insert(directed.size(), '{3, 32'(ONE), 32'(-ONE), 32'd0, 1'b1,
                             '{1'b1, 32'(1 << (FB - 1)), 32'(-(1 << (FB - 1)))}});
        directed.insert(directed.size(), '{3, S32_MAX, S32_MIN, 32'd0, 1'b0, blank});
        directed.insert(directed.size(), '{4, 32'(ONE), 32'(ONE), 32'd0, 1'b0, blank});
        directed.insert(directed.size(), '{4, S32_MIN, S32_MAX, S32_MIN, 1'b0, blank});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        current = 0;
        foreach (directed[i]) begin
            if (directed[i].view != current) begin
                s_tvalid <= 1'b0;
                current = directed[i].view;
                load_view(views[current]);
            end
            send_point(directed[i].x, directed[i].y, directed[i].z);
            // Typed-in results must agree with the predictor's own answer.
            if (directed[i].known && project_point(directed[i].x, directed[i].y,
                                                   directed[i].z) != directed[i].want) begin
                errors++;
                if (errors <= 10)
                    $display("directed row %0d: typed-in result disagrees", i);
            end
        end

        for (int n = 0; n < RANDOM_POINTS; n++) begin
            if (n % 100 == 0) begin
                s_tvalid <= 1'b0;
                load_view(random_view());
            end
            if (n == 150)
                no_idle = 1'b1;
            if (n == 230)
                no_idle = 1'b0;
            if (n == 320)
                hold_output = 1'b1;
            send_point(random_coord(), random_coord(), random_coord());
        end
        s_tvalid <= 1'b0;

        wait (pending_pixels.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0 && pending_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
